// ===== rtl/chained_hash_table_sorted_core_macros.svh =====
// ----------------------------------------------------------------------------
// chained hash table assertion macros
// implication checks on the rising clock edge, off during reset
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_SORTED_CORE_MACROS_SVH
`define CHAINED_HASH_TABLE_SORTED_CORE_MACROS_SVH

`define CHTS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define CHTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/chts_pkg.sv =====
// ----------------------------------------------------------------------------
// chts_pkg
// shared types and codes of the sorted chained hash table
// ----------------------------------------------------------------------------
`default_nettype none

package chts_pkg;

   localparam int KeyWidth    = 32;
   localparam int ModWidth    = 5;
   localparam int StatusWidth = 3;
   localparam int OpWidth     = 2;

   localparam logic [OpWidth-1:0] OP_INSERT  = 2'd0;
   localparam logic [OpWidth-1:0] OP_DELETE  = 2'd1;
   localparam logic [OpWidth-1:0] OP_LOOKUP  = 2'd2;
   localparam logic [OpWidth-1:0] OP_INVALID = 2'd3;

   localparam logic [StatusWidth-1:0] ST_DONE  = 3'd0;
   localparam logic [StatusWidth-1:0] ST_DUP   = 3'd1;
   localparam logic [StatusWidth-1:0] ST_FOUND = 3'd2;
   localparam logic [StatusWidth-1:0] ST_MISS  = 3'd3;
   localparam logic [StatusWidth-1:0] ST_FULL  = 3'd4;

   localparam logic [ModWidth-1:0] NUM_BUCKETS_RESET = 5'd10;
   localparam logic [KeyWidth-1:0] MISS_VALUE = '1;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [ModWidth-1:0] rem;
   } mod_res_type;

endpackage

`default_nettype wire

// ===== rtl/chts_mod.sv =====
// ----------------------------------------------------------------------------
// chts_mod
// bit-serial restoring remainder of a 32-bit magnitude by a small modulus
// ----------------------------------------------------------------------------
`default_nettype none

module chts_mod (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [chts_pkg::KeyWidth-1:0] mag,
   input  wire logic [chts_pkg::ModWidth-1:0] modulus,
   output chts_pkg::mod_res_type           res
);
   import chts_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [4:0]          cnt_ff;
   logic [KeyWidth-1:0] div_ff;
   logic [ModWidth-1:0] rem_ff;
   logic [ModWidth-1:0] mod_ff;
   logic [ModWidth:0]   shifted;
   logic [ModWidth:0]   rem_in;

   assign shifted = {rem_ff, div_ff[KeyWidth-1]};
   assign rem_in  = (shifted >= {1'b0, mod_ff}) ? shifted - {1'b0, mod_ff} : shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= mag;
         rem_ff <= '0;
         mod_ff <= modulus;
      end else if (busy_ff) begin
         div_ff <= {div_ff[KeyWidth-2:0], 1'b0};
         rem_ff <= rem_in[ModWidth-1:0];
      end
   end

   assign res.busy = busy_ff;
   assign res.done = done_ff;
   assign res.rem  = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/chained_hash_table_sorted_core.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table_sorted_core
// key/value hash table, buckets kept in ascending key order
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    req_type, req_key, req_value
//  rsp      out  rsp_valid/rsp_ready    rsp_status, rsp_found_value
//  csr      in   csr_valid/csr_ready    csr_num_buckets
//
//  an item's time is set by the 32-step serial remainder and by the
//  single-port slot scan and move
//  after reset a clearing pass over every bucket zeroes the fill counts
//  req_ready is low while an item is at work; a finished result waits in the
//  rsp register and the next request is taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_table_sorted_core #(
   parameter int MAX_BUCKETS      = 16,
   parameter int SLOTS_PER_BUCKET = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [chts_pkg::OpWidth-1:0]  req_type,
   input  wire logic [chts_pkg::KeyWidth-1:0] req_key,
   input  wire logic [chts_pkg::KeyWidth-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [chts_pkg::StatusWidth-1:0]   rsp_status,
   output logic [chts_pkg::KeyWidth-1:0]      rsp_found_value,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [chts_pkg::ModWidth-1:0] csr_num_buckets
);
   import chts_pkg::*;

   localparam int Total = MAX_BUCKETS * SLOTS_PER_BUCKET;
   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int AW = (Total > 1) ? $clog2(Total) : 1;
   localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_MOD       = 4'd2;
   localparam logic [3:0] S_FILL_REQ  = 4'd3;
   localparam logic [3:0] S_FILL_WAIT = 4'd4;
   localparam logic [3:0] S_SCAN_REQ  = 4'd5;
   localparam logic [3:0] S_SCAN_CHK  = 4'd6;
   localparam logic [3:0] S_DECIDE    = 4'd7;
   localparam logic [3:0] S_SHIFT_REQ = 4'd8;
   localparam logic [3:0] S_SHIFT_WR  = 4'd9;
   localparam logic [3:0] S_DEL_REQ   = 4'd10;
   localparam logic [3:0] S_DEL_WR    = 4'd11;
   localparam logic [3:0] S_DONE      = 4'd12;

   logic [3:0]             state_ff;
   logic [ModWidth-1:0]    num_buckets_ff;
   logic [OpWidth-1:0]     op_ff;
   logic [KeyWidth-1:0]    key_ff;
   logic [KeyWidth-1:0]    value_ff;
   logic [BW-1:0]          bucket_ff;
   logic [AW-1:0]          base_ff;
   logic [FW-1:0]          fill_ff;
   logic [FW-1:0]          pos_ff;
   logic [FW-1:0]          idx_ff;
   logic                   hit_ff;
   logic [KeyWidth-1:0]    hit_value_ff;
   logic [StatusWidth-1:0] status_ff;
   logic [KeyWidth-1:0]    result_ff;
   logic [BW-1:0]          clr_ff;
   logic                   rsp_valid_ff;
   logic [StatusWidth-1:0] rsp_status_ff;
   logic [KeyWidth-1:0]    rsp_value_ff;

   logic [2*KeyWidth-1:0]  ent_mem [Total];
   logic [FW-1:0]          fill_mem [MAX_BUCKETS];
   logic [2*KeyWidth-1:0]  ent_rdata_ff;
   logic [FW-1:0]          fill_rdata_ff;

   logic                   ent_we;
   logic [AW-1:0]          ent_waddr;
   logic [AW-1:0]          ent_raddr;
   logic [2*KeyWidth-1:0]  ent_wdata;
   logic                   fill_we;
   logic [BW-1:0]          fill_waddr;
   logic [FW-1:0]          fill_wdata;

   logic                   accept;
   logic                   mod_start;
   logic [KeyWidth-1:0]    mag;
   logic [ModWidth-1:0]    eff_mod;
   mod_res_type            mod_res;
   logic [KeyWidth-1:0]    rd_key;
   logic [KeyWidth-1:0]    rd_value;
   logic                   del_last;

   function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] base,
                                               input logic [FW-1:0] slot);
      slot_addr = AW'(int'(base) + int'(slot));
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign mod_start = accept && (req_type != OP_INVALID);
   assign mag       = req_key[KeyWidth-1] ? (32'd0 - req_key) : req_key;
   assign rd_key    = ent_rdata_ff[2*KeyWidth-1:KeyWidth];
   assign rd_value  = ent_rdata_ff[KeyWidth-1:0];
   assign del_last  = ({1'b0, idx_ff} + {{FW{1'b0}}, 1'b1}) >= {1'b0, fill_ff};

   always_comb begin
      if (num_buckets_ff == '0) begin
         eff_mod = 5'd1;
      end else if (int'(num_buckets_ff) > MAX_BUCKETS) begin
         eff_mod = ModWidth'(MAX_BUCKETS);
      end else begin
         eff_mod = num_buckets_ff;
      end
   end

   chts_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .mag     (mag),
      .modulus (eff_mod),
      .res     (mod_res)
   );

   // memory port control
   always_comb begin
      ent_we     = 1'b0;
      ent_waddr  = slot_addr(base_ff, idx_ff);
      ent_raddr  = slot_addr(base_ff, pos_ff);
      ent_wdata  = ent_rdata_ff;
      fill_we    = 1'b0;
      fill_waddr = bucket_ff;
      fill_wdata = fill_ff;
      unique case (state_ff) inside
         S_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            fill_wdata = '0;
         end
         S_SHIFT_REQ: begin
            if (idx_ff == pos_ff) begin
               ent_we     = 1'b1;
               ent_waddr  = slot_addr(base_ff, pos_ff);
               ent_wdata  = {key_ff, value_ff};
               fill_we    = 1'b1;
               fill_wdata = fill_ff + FW'(1);
            end else begin
               ent_raddr = slot_addr(base_ff, idx_ff - FW'(1));
            end
         end
         S_SHIFT_WR, S_DEL_WR: begin
            ent_we = 1'b1;
         end
         S_DEL_REQ: begin
            if (del_last) begin
               fill_we    = 1'b1;
               fill_wdata = fill_ff - FW'(1);
            end else begin
               ent_raddr = slot_addr(base_ff, idx_ff + FW'(1));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rdata_ff <= ent_mem[ent_raddr];
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_rdata_ff <= fill_mem[bucket_ff];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         num_buckets_ff <= NUM_BUCKETS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            num_buckets_ff <= csr_num_buckets;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + BW'(1);
               if (clr_ff == BW'(MAX_BUCKETS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  op_ff     <= req_type;
                  key_ff    <= req_key;
                  value_ff  <= req_value;
                  status_ff <= ST_MISS;
                  result_ff <= (req_type == OP_LOOKUP) ? MISS_VALUE : '0;
                  state_ff  <= (req_type == OP_INVALID) ? S_DONE : S_MOD;
               end
            end
            S_MOD: begin
               if (mod_res.done) begin
                  if (key_ff[KeyWidth-1] && (mod_res.rem != '0)) begin
                     state_ff <= S_DONE;
                  end else begin
                     bucket_ff <= BW'(mod_res.rem);
                     base_ff   <= AW'(int'(mod_res.rem) * SLOTS_PER_BUCKET);
                     state_ff  <= S_FILL_REQ;
                  end
               end
            end
            S_FILL_REQ: begin
               state_ff <= S_FILL_WAIT;
            end
            S_FILL_WAIT: begin
               fill_ff  <= fill_rdata_ff;
               pos_ff   <= '0;
               hit_ff   <= 1'b0;
               state_ff <= S_SCAN_REQ;
            end
            S_SCAN_REQ: begin
               state_ff <= (pos_ff == fill_ff) ? S_DECIDE : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               if ($signed(rd_key) < $signed(key_ff)) begin
                  pos_ff   <= pos_ff + FW'(1);
                  state_ff <= S_SCAN_REQ;
               end else begin
                  hit_ff       <= (rd_key == key_ff);
                  hit_value_ff <= rd_value;
                  state_ff     <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               state_ff <= S_DONE;
               case (op_ff)
                  OP_INSERT: begin
                     if (hit_ff) begin
                        status_ff <= ST_DUP;
                     end else if (int'(fill_ff) >= SLOTS_PER_BUCKET) begin
                        status_ff <= ST_FULL;
                     end else begin
                        idx_ff   <= fill_ff;
                        state_ff <= S_SHIFT_REQ;
                     end
                  end
                  OP_DELETE: begin
                     if (hit_ff) begin
                        idx_ff   <= pos_ff;
                        state_ff <= S_DEL_REQ;
                     end
                  end
                  default: begin
                     if (hit_ff) begin
                        status_ff <= ST_FOUND;
                        result_ff <= hit_value_ff;
                     end
                  end
               endcase
            end
            S_SHIFT_REQ: begin
               if (idx_ff == pos_ff) begin
                  status_ff <= ST_DONE;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_SHIFT_WR;
               end
            end
            S_SHIFT_WR: begin
               idx_ff   <= idx_ff - FW'(1);
               state_ff <= S_SHIFT_REQ;
            end
            S_DEL_REQ: begin
               if (del_last) begin
                  status_ff <= ST_DONE;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_DEL_WR;
               end
            end
            S_DEL_WR: begin
               idx_ff   <= idx_ff + FW'(1);
               state_ff <= S_DEL_REQ;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_value_ff  <= result_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;

`include "chained_hash_table_sorted_core_macros.svh"

   `CHTS_ASSERT_IMPL(a_mod_done_in_mod, clock, reset, mod_res.done, state_ff == S_MOD)
   `CHTS_ASSERT_IMPL(a_pos_in_fill, clock, reset, state_ff == S_DECIDE, pos_ff <= fill_ff)
   `CHTS_ASSERT_NEXT(a_accept_starts, clock, reset, accept,
                     (state_ff == S_MOD && mod_res.busy) || state_ff == S_DONE)

endmodule

`default_nettype wire

// ===== verif/chained_hash_table_sorted_core_tb.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table_sorted_core_tb
// drives random and directed insert, delete, lookup and invalid transfers through the
// sorted chained hash table, predicts every response with a model of the
// bucket store and compares status and value in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_table_sorted_core_tb;
   import chts_pkg::*;

   localparam int NB = 16;
   localparam int SL = 8;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [KeyWidth-1:0]    value;
   } rsp_type;

   class hash_scoreboard;
      logic [KeyWidth-1:0] keys [NB*SL];
      logic [KeyWidth-1:0] vals [NB*SL];
      int                  fill [NB];
      logic [ModWidth-1:0] modulus;
      rsp_type             pending [$];
      int                  errors;

      function void clear();
         for (int b = 0; b < NB; b++) fill[b] = 0;
         modulus = NUM_BUCKETS_RESET;
         errors = 0;
      endfunction

      function void note_request(logic [OpWidth-1:0] op, logic [KeyWidth-1:0] k,
                                 logic [KeyWidth-1:0] v);
         int unsigned m, mag, r, base, pos, n;
         bit hit;
         rsp_type e;
         e.status = ST_MISS;
         e.value = (op == OP_LOOKUP) ? MISS_VALUE : '0;
         m = modulus;
         if (m == 0) m = 1;
         if (m > NB) m = NB;
         mag = k[31] ? (0 - k) : k;
         r = mag % m;
         if (op != OP_INVALID && !(k[31] && r != 0)) begin
            base = r * SL;
            n = fill[r];
            pos = 0;
            while (pos < n && $signed(keys[base+pos]) < $signed(k)) pos++;
            hit = pos < n && keys[base+pos] == k;
            if (op == OP_INSERT) begin
               if (hit) e.status = ST_DUP;
               else if (n >= SL) e.status = ST_FULL;
               else begin
                  for (int i = n; i > pos; i--) begin
                     keys[base+i] = keys[base+i-1];
                     vals[base+i] = vals[base+i-1];
                  end
                  keys[base+pos] = k;
                  vals[base+pos] = v;
                  fill[r] = n + 1;
                  e.status = ST_DONE;
               end
            end else if (op == OP_DELETE) begin
               if (hit) begin
                  for (int i = pos; i + 1 < n; i++) begin
                     keys[base+i] = keys[base+i+1];
                     vals[base+i] = vals[base+i+1];
                  end
                  fill[r] = n - 1;
                  e.status = ST_DONE;
               end
            end else if (hit) begin
               e.status = ST_FOUND;
               e.value = vals[base+pos];
            end
         end
         pending.insert(pending.size(), e);
      endfunction

      function void check_response(logic [StatusWidth-1:0] s, logic [KeyWidth-1:0] v);
         rsp_type e;
         if (pending.size() == 0) begin
            report_error($sformatf("unexpected response status %0d", s));
            return;
         end
         e = pending.pop_front();
         if (s !== e.status)
            report_error($sformatf("status %0d, wanted %0d", s, e.status));
         if (v !== e.value)
            report_error($sformatf("value %h, wanted %h", v, e.value));
      endfunction

      function void report_error(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OpWidth-1:0]     req_type = '0;
   logic [KeyWidth-1:0]    req_key = '0;
   logic [KeyWidth-1:0]    req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [StatusWidth-1:0] rsp_status;
   logic [KeyWidth-1:0]    rsp_found_value;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [ModWidth-1:0]    csr_num_buckets = '0;

   hash_scoreboard sb;
   int idle_cycles = 0;
   bit stim_done = 1'b0;
   bit no_gaps = 1'b0;

   always #6 clock = ~clock;

   chained_hash_table_sorted_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_found_value(rsp_found_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_num_buckets(csr_num_buckets)
   );

   function automatic int gap_len();
      if (no_gaps) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
      return $urandom_range(0, 3);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_type, req_key, req_value);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_status, rsp_found_value);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired");
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : rsp_side
      int g;
      @(negedge clock);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_request(logic [OpWidth-1:0] op, logic [KeyWidth-1:0] k,
                               logic [KeyWidth-1:0] v);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_type <= op;
      req_key <= k;
      req_value <= v;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_modulus(logic [ModWidth-1:0] m);
      drain();
      csr_num_buckets <= m;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.modulus = m;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [KeyWidth-1:0] pick_key(int mode);
      case (mode)
         0: return $urandom_range(0, 200);
         1: return -$urandom_range(0, 40);
         2: return $urandom_range(0, 15) * 16;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int count);
      logic [OpWidth-1:0] op;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) op = OP_INSERT;
         else if (r < 70) op = OP_DELETE;
         else if (r < 97) op = OP_LOOKUP;
         else op = OP_INVALID;
         send_request(op, pick_key($urandom_range(0, 3)), $urandom);
      end
   endtask

   initial begin : main
      logic [ModWidth-1:0] mods [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd3};
      sb = new();
      sb.clear();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_request(OP_LOOKUP, 32'd5, 32'd0);
      send_request(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
      send_request(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
      send_request(OP_INSERT, -32'sd10, 32'd1);
      send_request(OP_INSERT, -32'sd3, 32'd2);
      send_request(OP_LOOKUP, -32'sd10, 32'd0);
      send_request(OP_LOOKUP, -32'sd3, 32'd0);
      send_request(OP_DELETE, -32'sd3, 32'd0);
      for (int i = 0; i < 9; i++) send_request(OP_INSERT, 32'(i * 10), 32'(i));
      send_request(OP_INSERT, 32'd40, 32'd99);
      send_request(OP_LOOKUP, 32'd70, 32'd0);
      send_request(OP_DELETE, 32'd30, 32'd0);
      send_request(OP_DELETE, 32'd30, 32'd0);
      send_request(OP_INVALID, 32'hffff_ffff, 32'hffff_ffff);
      write_modulus(5'd4);
      send_request(OP_LOOKUP, 32'd40, 32'd0);
      send_request(OP_LOOKUP, 32'd0, 32'd0);
      random_phase(150);
      foreach (mods[j]) begin
         write_modulus(mods[j]);
         no_gaps = (j == 2);
         random_phase(280);
      end
      no_gaps = 1'b0;
      drain();
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
